[src/owvm_pkg.sv]
// Shared types, constants and the sine table function for the omni-wheel velocity mixer.
// Used by owvm_wheel_unit and omni_wheel_velocity_mixer; no dependencies.
package owvm_pkg;

  // field widths
  localparam int VEL_W   = 32;  // signed Q15.16 velocities
  localparam int SPEED_W = 32;  // signed Q15.16 wheel speed
  localparam int LEN_W   = 31;  // unsigned Q15.16 lengths
  localparam int AGE_W   = 32;
  localparam int WCNT_W  = 4;
  localparam int OFS_W   = 12;
  localparam int IDX_OUT_W = 3;
  localparam int TAB_W   = 15;  // magnitude of a quarter-wave table entry
  localparam int ACC_W   = 64;  // exact Q32 sum
  localparam int FRAC_SHIFT = 32;

  // APB register map
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WHEEL_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_OFS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROBOT_RAD   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INV_WHEEL   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;

  localparam logic [WCNT_W-1:0] RST_WHEEL_COUNT = 4'd3;
  localparam logic [OFS_W-1:0]  RST_ANGLE_OFS   = 12'd0;
  localparam logic [LEN_W-1:0]  RST_ROBOT_RAD   = 31'd65536;
  localparam logic [LEN_W-1:0]  RST_INV_WHEEL   = 31'd655360;
  localparam logic [AGE_W-1:0]  RST_TIMEOUT     = 32'd500;

  localparam int MIN_WHEELS     = 3;
  localparam int DEF_MAX_WHEELS = 8;
  localparam int DEF_ANGLE_BITS = 12;

  // item kinds
  localparam logic CMD_VELOCITY = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // which product term the wheel unit is accumulating
  localparam logic [1:0] TERM_SIN = 2'd0;
  localparam logic [1:0] TERM_COS = 2'd1;
  localparam logic [1:0] TERM_YAW = 2'd2;

  localparam real TWO_PI = 6.283185307179586;

  typedef struct packed {
    logic               valid;
    logic [SPEED_W-1:0] speed;
  } owvm_res_t;

  // round(32767 * sin(2*pi*j / 2**angle_bits)), first quarter only
  function automatic int sine_entry(input int j, input int angle_bits);
    real x;
    int  v;
    x = 32767.0 * $sin(TWO_PI * j * (2.0 ** (-angle_bits)));
    v = $rtoi(x + 0.5);
    if (v > 32767) v = 32767;
    if (v < 0) v = 0;
    return v;
  endfunction

endpackage

[src/owvm_wheel_unit.sv]
// Per-wheel speed datapath: quarter-wave sine ROM, bit-serial multiply-accumulate
// of the three terms, bit-serial scale by inverse wheel radius, round and saturate.
// Depends on owvm_pkg.
module owvm_wheel_unit #(
  parameter int ANGLE_BITS = owvm_pkg::DEF_ANGLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              ack,
  input  logic [ANGLE_BITS-1:0]             angle,
  input  logic signed [owvm_pkg::VEL_W-1:0] ref_x,
  input  logic signed [owvm_pkg::VEL_W-1:0] ref_y,
  input  logic signed [owvm_pkg::VEL_W-1:0] ref_yaw,
  input  logic [owvm_pkg::LEN_W-1:0]        radius,
  input  logic [owvm_pkg::LEN_W-1:0]        inv_radius,
  output owvm_pkg::owvm_res_t               res
);
  import owvm_pkg::*;

  localparam int QTR_BITS  = ANGLE_BITS - 2;
  localparam int TAB_DEPTH = (1 << QTR_BITS) + 1;
  localparam int IDX_W     = QTR_BITS + 1;
  localparam int PROD_W    = ACC_W + LEN_W;
  localparam int MAG_W     = PROD_W - FRAC_SHIFT;
  localparam int CNT_W     = $clog2(LEN_W);

  localparam logic [ANGLE_BITS-1:0] QTR_ANGLE = ANGLE_BITS'(1 << QTR_BITS);
  localparam logic [IDX_W-1:0]      QTR_IDX   = IDX_W'(1 << QTR_BITS);
  localparam logic [ACC_W-1:0]      RND_HALF  = ACC_W'(64'h8000_0000);
  localparam logic [MAG_W-1:0]      LIM_POS   = MAG_W'(64'h7FFF_FFFF);
  localparam logic [MAG_W-1:0]      LIM_NEG   = MAG_W'(64'h8000_0000);

  localparam logic [2:0] U_IDLE  = 3'd0;
  localparam logic [2:0] U_READ  = 3'd1;
  localparam logic [2:0] U_LOAD  = 3'd2;
  localparam logic [2:0] U_MUL   = 3'd3;
  localparam logic [2:0] U_SCALE = 3'd4;
  localparam logic [2:0] U_DONE  = 3'd5;

  logic [TAB_W-1:0] sine_tab [TAB_DEPTH];

  for (genvar gj = 0; gj < TAB_DEPTH; gj++) begin : g_tab
    assign sine_tab[gj] = TAB_W'(sine_entry(gj, ANGLE_BITS));
  end

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        term_r, term_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  mcand_r, mcand_nxt;
  logic [LEN_W-1:0]  mplier_r, mplier_nxt;
  logic              sub_r, sub_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [TAB_W-1:0]  rom_q_r;

  logic [ANGLE_BITS-1:0] angle_eff;
  logic [1:0]            quad;
  logic [IDX_W-1:0]      tab_idx;
  logic                  tab_neg;
  logic [ACC_W-1:0]      x_ext, y_ext, yaw_ext;
  logic [ACC_W:0]        scale_sum;
  logic [MAG_W-1:0]      res_mag, res_lim, res_sat;

  // cosine is the sine a quarter turn later
  assign angle_eff = angle + ((term_r == TERM_COS) ? QTR_ANGLE : '0);
  assign quad      = angle_eff[ANGLE_BITS-1 -: 2];
  assign tab_idx   = quad[0] ? IDX_W'(QTR_IDX - {1'b0, angle_eff[QTR_BITS-1:0]})
                             : {1'b0, angle_eff[QTR_BITS-1:0]};
  assign tab_neg   = quad[1];

  assign x_ext   = {{(ACC_W-VEL_W){ref_x[VEL_W-1]}}, ref_x};
  assign y_ext   = {{(ACC_W-VEL_W){ref_y[VEL_W-1]}}, ref_y};
  assign yaw_ext = {{(ACC_W-VEL_W){ref_yaw[VEL_W-1]}}, ref_yaw};

  assign scale_sum = {1'b0, prod_r[PROD_W-1:LEN_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);

  always_comb begin
    state_nxt  = state_r;
    term_nxt   = term_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    sub_nxt    = sub_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    case (state_r)
      U_IDLE: begin
        if (start) begin
          acc_nxt   = '0;
          term_nxt  = TERM_SIN;
          state_nxt = U_READ;
        end
      end
      U_READ: begin
        state_nxt = U_LOAD;
      end
      U_LOAD: begin
        case (term_r)
          TERM_SIN: begin
            mcand_nxt  = x_ext << 1;
            mplier_nxt = LEN_W'(rom_q_r);
            sub_nxt    = tab_neg;
          end
          TERM_COS: begin
            mcand_nxt  = y_ext << 1;
            mplier_nxt = LEN_W'(rom_q_r);
            sub_nxt    = !tab_neg;
          end
          default: begin
            mcand_nxt  = yaw_ext;
            mplier_nxt = radius;
            sub_nxt    = 1'b1;
          end
        endcase
        state_nxt = U_MUL;
      end
      U_MUL: begin
        // one multiplier bit per cycle, stops early once the rest is zero
        if (mplier_r != '0) begin
          if (mplier_r[0]) begin
            acc_nxt = sub_r ? acc_r - mcand_r : acc_r + mcand_r;
          end
          mcand_nxt  = mcand_r << 1;
          mplier_nxt = mplier_r >> 1;
        end else if (term_r == TERM_YAW) begin
          neg_nxt   = acc_r[ACC_W-1];
          mcand_nxt = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;
          // the upper half starts at one half LSB of the result: rounding for free
          prod_nxt  = {RND_HALF, inv_radius};
          cnt_nxt   = '0;
          state_nxt = U_SCALE;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = U_READ;
        end
      end
      U_SCALE: begin
        prod_nxt = {scale_sum, prod_r[LEN_W-1:1]};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(LEN_W - 1)) begin
          state_nxt = U_DONE;
        end
      end
      U_DONE: begin
        if (ack) begin
          state_nxt = U_IDLE;
        end
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    term_r   <= term_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    sub_r    <= sub_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
    rom_q_r  <= sine_tab[tab_idx];
  end

  assign res_mag = prod_r[PROD_W-1:FRAC_SHIFT];
  assign res_lim = neg_r ? LIM_NEG : LIM_POS;
  assign res_sat = (res_mag > res_lim) ? res_lim : res_mag;

  assign res.valid = (state_r == U_DONE);
  assign res.speed = neg_r ? (~res_sat[SPEED_W-1:0] + SPEED_W'(1)) : res_sat[SPEED_W-1:0];

endmodule

[src/omni_wheel_velocity_mixer.sv]
// Omni-wheel velocity mixer top level: APB registers, command hold and timeout,
// tick handling, wheel sequencing and output register. Depends on owvm_pkg, owvm_wheel_unit.
//
// A velocity command request never produces output. A tick request ages the held
// command, updates the references and, once references exist, emits one speed per
// wheel in wheel order with last set on the final wheel. A shared bit-serial multiplier
// steps one multiplier bit per cycle, stopping once the remaining bits are zero, through
// the sine term (up to 15 bits), the cosine term (up to 15 bits) and the yaw term (up to
// 31 bits of the robot radius). The product is then scaled bit-serially by the inverse
// wheel radius, rounded and saturated. The next wheel launches the cycle after the
// previous result moves to the output register, so a stalled output stretches the tick.
// The input is stalled until the last wheel result is in the output register; a finished
// result waits there while the next tick request is taken. The wheel count is clamped to
// 3..MAX_WHEELS.
module omni_wheel_velocity_mixer #(
  parameter int MAX_WHEELS = owvm_pkg::DEF_MAX_WHEELS,
  parameter int ANGLE_BITS = owvm_pkg::DEF_ANGLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // APB configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [owvm_pkg::ADDR_W-1:0]           paddr,
  input  logic [owvm_pkg::DATA_W-1:0]           pwdata,
  output logic [owvm_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic signed [owvm_pkg::VEL_W-1:0]     in_vel_x,
  input  logic signed [owvm_pkg::VEL_W-1:0]     in_vel_y,
  input  logic signed [owvm_pkg::VEL_W-1:0]     in_yaw_rate,
  input  logic                                  in_values_ok,
  input  logic [owvm_pkg::AGE_W-1:0]            in_arrival_age,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [owvm_pkg::IDX_OUT_W-1:0]        out_wheel_index,
  output logic signed [owvm_pkg::SPEED_W-1:0]   out_wheel_speed,
  output logic                                  out_last
);
  import owvm_pkg::*;

  localparam int TURN  = 1 << ANGLE_BITS;
  localparam int N_W   = $clog2(MAX_WHEELS + 1);
  localparam int WHL_W = $clog2(MAX_WHEELS);
  localparam int RM_W  = $clog2(MAX_WHEELS);

  // per-count angle step: floor(TURN/n) and TURN mod n
  logic [ANGLE_BITS-1:0] step_q [MAX_WHEELS+1];
  logic [RM_W-1:0]       step_r [MAX_WHEELS+1];

  for (genvar gn = 0; gn <= MAX_WHEELS; gn++) begin : g_step
    localparam int DIV = (gn < MIN_WHEELS) ? MIN_WHEELS : gn;
    assign step_q[gn] = ANGLE_BITS'(TURN / DIV);
    assign step_r[gn] = RM_W'(TURN % DIV);
  end

  // configuration
  logic [WCNT_W-1:0] wheel_count_r;
  logic [OFS_W-1:0]  angle_ofs_r;
  logic [LEN_W-1:0]  robot_rad_r;
  logic [LEN_W-1:0]  inv_wheel_r;
  logic [AGE_W-1:0]  timeout_r;

  // command and reference state
  logic [VEL_W-1:0]  held_x_r, held_y_r, held_yaw_r;
  logic              held_ok_r;
  logic [AGE_W-1:0]  age_r;
  logic [VEL_W-1:0]  ref_x_r, ref_y_r, ref_yaw_r;
  logic              ref_set_r;

  // wheel sequencing
  logic                  run_r;
  logic                  launch_r;
  logic [WHL_W-1:0]      wheel_r;
  logic [ANGLE_BITS-1:0] base_q_r;
  logic [RM_W-1:0]       base_rm_r;

  // output register
  logic                  out_valid_r;
  logic [IDX_OUT_W-1:0]  out_index_r;
  logic [SPEED_W-1:0]    out_speed_r;
  logic                  out_last_r;

  logic                  wr_en;
  logic                  in_acc;
  logic                  is_tick;
  logic                  cmd_fresh;
  logic [AGE_W-1:0]      age_inc;
  logic                  brake;
  logic                  ref_set_nxt;
  logic [N_W-1:0]        n_sel;
  logic                  last_wheel;
  logic [RM_W:0]         rm_sum;
  logic                  rm_wrap;
  logic [ANGLE_BITS-1:0] wheel_angle;
  logic                  ack;
  owvm_res_t             unit_res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_WHEEL_COUNT: prdata = DATA_W'(wheel_count_r);
      REG_ANGLE_OFS:   prdata = DATA_W'(angle_ofs_r);
      REG_ROBOT_RAD:   prdata = DATA_W'(robot_rad_r);
      REG_INV_WHEEL:   prdata = DATA_W'(inv_wheel_r);
      REG_TIMEOUT:     prdata = DATA_W'(timeout_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_count_r <= RST_WHEEL_COUNT;
      angle_ofs_r   <= RST_ANGLE_OFS;
      robot_rad_r   <= RST_ROBOT_RAD;
      inv_wheel_r   <= RST_INV_WHEEL;
      timeout_r     <= RST_TIMEOUT;
    end else if (wr_en) begin
      case (paddr[ADDR_W-1:2])
        REG_WHEEL_COUNT: wheel_count_r <= pwdata[WCNT_W-1:0];
        REG_ANGLE_OFS:   angle_ofs_r   <= pwdata[OFS_W-1:0];
        REG_ROBOT_RAD:   robot_rad_r   <= pwdata[LEN_W-1:0];
        REG_INV_WHEEL:   inv_wheel_r   <= pwdata[LEN_W-1:0];
        REG_TIMEOUT:     timeout_r     <= pwdata[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = run_r;
  assign in_acc    = in_valid && !in_stall;
  assign is_tick   = (in_cmd == CMD_TICK);
  assign cmd_fresh = (timeout_r == '0) || (in_arrival_age < timeout_r);

  assign age_inc     = (age_r == '1) ? age_r : age_r + AGE_W'(1);
  assign brake       = (age_inc > timeout_r);
  assign ref_set_nxt = ref_set_r || brake || held_ok_r;

  always_comb begin
    if (32'(wheel_count_r) < MIN_WHEELS) begin
      n_sel = N_W'(MIN_WHEELS);
    end else if (32'(wheel_count_r) > MAX_WHEELS) begin
      n_sel = N_W'(MAX_WHEELS);
    end else begin
      n_sel = N_W'(wheel_count_r);
    end
  end

  assign last_wheel  = ((N_W+1)'(wheel_r) + (N_W+1)'(1)) == (N_W+1)'(n_sel);
  assign rm_sum      = {1'b0, base_rm_r} + {1'b0, step_r[n_sel]};
  assign rm_wrap     = (rm_sum >= (RM_W+1)'(n_sel));
  assign wheel_angle = base_q_r + ANGLE_BITS'(angle_ofs_r);

  assign ack = unit_res.valid && (!out_valid_r || !out_stall);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_ok_r   <= 1'b0;
      age_r       <= '0;
      ref_set_r   <= 1'b0;
      run_r       <= 1'b0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      launch_r <= 1'b0;
      if (in_acc) begin
        if (!is_tick) begin
          if (cmd_fresh) begin
            held_ok_r <= in_values_ok;
            age_r     <= in_arrival_age;
          end
        end else begin
          age_r     <= age_inc;
          ref_set_r <= ref_set_nxt;
          if (ref_set_nxt) begin
            run_r    <= 1'b1;
            launch_r <= 1'b1;
          end
        end
      end
      if (ack) begin
        if (last_wheel) begin
          run_r <= 1'b0;
        end else begin
          launch_r <= 1'b1;
        end
      end
      if (ack) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!is_tick) begin
        if (cmd_fresh) begin
          held_x_r   <= in_vel_x;
          held_y_r   <= in_vel_y;
          held_yaw_r <= in_yaw_rate;
        end
      end else begin
        if (brake) begin
          ref_x_r   <= '0;
          ref_y_r   <= '0;
          ref_yaw_r <= '0;
        end else if (held_ok_r) begin
          ref_x_r   <= held_x_r;
          ref_y_r   <= held_y_r;
          ref_yaw_r <= held_yaw_r;
        end
        wheel_r   <= '0;
        base_q_r  <= '0;
        base_rm_r <= '0;
      end
    end
    if (ack) begin
      out_index_r <= IDX_OUT_W'(wheel_r);
      out_speed_r <= unit_res.speed;
      out_last_r  <= last_wheel;
      // next wheel angle: add floor(TURN/n), carry the remainder
      wheel_r <= wheel_r + WHL_W'(1);
      if (rm_wrap) begin
        base_rm_r <= RM_W'(rm_sum - (RM_W+1)'(n_sel));
        base_q_r  <= base_q_r + step_q[n_sel] + ANGLE_BITS'(1);
      end else begin
        base_rm_r <= RM_W'(rm_sum);
        base_q_r  <= base_q_r + step_q[n_sel];
      end
    end
  end

  owvm_wheel_unit #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_wheel (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (launch_r),
    .ack        (ack),
    .angle      (wheel_angle),
    .ref_x      (ref_x_r),
    .ref_y      (ref_y_r),
    .ref_yaw    (ref_yaw_r),
    .radius     (robot_rad_r),
    .inv_radius (inv_wheel_r),
    .res        (unit_res)
  );

  assign out_valid       = out_valid_r;
  assign out_wheel_index = out_index_r;
  assign out_wheel_speed = out_speed_r;
  assign out_last        = out_last_r;

endmodule

[bench/wheel_speed_checker.sv]
// Wheel speed checker: mirrors the register writes and accepted requests of the mixer,
// predicts each wheel speed and compares every accepted result in order.
// Depends on owvm_pkg.
module wheel_speed_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [owvm_pkg::ADDR_W-1:0]         paddr,
  input  logic [owvm_pkg::DATA_W-1:0]         pwdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_cmd,
  input  logic signed [owvm_pkg::VEL_W-1:0]   in_vel_x,
  input  logic signed [owvm_pkg::VEL_W-1:0]   in_vel_y,
  input  logic signed [owvm_pkg::VEL_W-1:0]   in_yaw_rate,
  input  logic                                in_values_ok,
  input  logic [owvm_pkg::AGE_W-1:0]          in_arrival_age,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [owvm_pkg::IDX_OUT_W-1:0]      out_wheel_index,
  input  logic signed [owvm_pkg::SPEED_W-1:0] out_wheel_speed,
  input  logic                                out_last,
  output int                                  fail_count,
  output int                                  pending
);
  import owvm_pkg::*;

  localparam int TURN    = 1 << DEF_ANGLE_BITS;
  localparam int QUARTER = TURN / 4;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]      index;
    logic signed [SPEED_W-1:0] speed;
    logic                      last;
  } wheel_result_t;

  int quarter_wave [0:QUARTER];

  logic [WCNT_W-1:0] wheels_cfg;
  logic [OFS_W-1:0]  offset_cfg;
  logic [LEN_W-1:0]  radius_cfg;
  logic [LEN_W-1:0]  inv_radius_cfg;
  logic [AGE_W-1:0]  timeout_cfg;

  logic signed [VEL_W-1:0] hold_vx, hold_vy, hold_wz;
  logic signed [VEL_W-1:0] ref_vx, ref_vy, ref_wz;
  logic                    hold_ok, ref_valid;
  logic [AGE_W-1:0]        hold_age;

  wheel_result_t expected_speeds [$];
  int            errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    for (int j = 0; j <= QUARTER; j++)
      quarter_wave[j] = $rtoi(32767.0 * $sin(TWO_PI * j / TURN) + 0.5);
  end

  // signed Q1.15 sine at k turn units, folded from the first quarter
  function automatic longint wave_at(input int k);
    int     kk, q, r;
    longint v;
    kk = k & (TURN - 1);
    q  = kk / QUARTER;
    r  = kk % QUARTER;
    v  = (q & 1) ? quarter_wave[QUARTER - r] : quarter_wave[r];
    return (q & 2) ? -v : v;
  endfunction

  function automatic logic [SPEED_W-1:0] predict_speed(input int angle);
    longint       s, c, acc;
    logic         neg;
    logic [63:0]  mag;
    logic [127:0] prod, rounded, cap;
    s   = wave_at(angle);
    c   = wave_at(angle + QUARTER);
    acc = s * longint'(ref_vx) * 2 - c * longint'(ref_vy) * 2
          - longint'(ref_wz) * longint'(radius_cfg);
    neg = acc < 0;
    mag = neg ? 64'(-acc) : 64'(acc);
    prod = {64'd0, mag} * {97'd0, inv_radius_cfg};
    rounded = (prod + 128'h8000_0000) >> 32;
    cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (rounded > cap) rounded = cap;
    return neg ? (32'd0 - rounded[31:0]) : rounded[31:0];
  endfunction

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
    case (idx)
      REG_WHEEL_COUNT: wheels_cfg     = value[WCNT_W-1:0];
      REG_ANGLE_OFS:   offset_cfg     = value[OFS_W-1:0];
      REG_ROBOT_RAD:   radius_cfg     = value[LEN_W-1:0];
      REG_INV_WHEEL:   inv_radius_cfg = value[LEN_W-1:0];
      REG_TIMEOUT:     timeout_cfg    = value[AGE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_request();
    int            n, angle;
    wheel_result_t item;
    if (in_cmd == CMD_VELOCITY) begin
      // stale commands are dropped unless the timeout is disabled
      if (!(timeout_cfg != 0 && in_arrival_age >= timeout_cfg)) begin
        hold_vx  = in_vel_x;
        hold_vy  = in_vel_y;
        hold_wz  = in_yaw_rate;
        hold_ok  = in_values_ok;
        hold_age = in_arrival_age;
      end
    end else begin
      if (hold_age != '1) hold_age = hold_age + 1;
      if (hold_age > timeout_cfg) begin
        ref_vx = '0;
        ref_vy = '0;
        ref_wz = '0;
        ref_valid = 1'b1;
      end else if (hold_ok) begin
        ref_vx = hold_vx;
        ref_vy = hold_vy;
        ref_wz = hold_wz;
        ref_valid = 1'b1;
      end
      if (ref_valid) begin
        n = wheels_cfg;
        if (n < MIN_WHEELS) n = MIN_WHEELS;
        if (n > DEF_MAX_WHEELS) n = DEF_MAX_WHEELS;
        for (int i = 0; i < n; i++) begin
          angle = ((i * TURN) / n + offset_cfg) & (TURN - 1);
          item.index = i[IDX_OUT_W-1:0];
          item.speed = predict_speed(angle);
          item.last  = (i == n - 1);
          expected_speeds.insert(expected_speeds.size(), item);
        end
      end
    end
  endtask

  task automatic check_result();
    wheel_result_t want;
    if (expected_speeds.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected wheel result: index %0d speed %0d last %0d",
                 $time, out_wheel_index, out_wheel_speed, out_last);
    end else begin
      want = expected_speeds.pop_front();
      if (out_wheel_index !== want.index || out_wheel_speed !== want.speed ||
          out_last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: wheel mismatch: expected index %0d speed %0d last %0d, got %0d %0d %0d",
                   $time, want.index, want.speed, want.last,
                   out_wheel_index, out_wheel_speed, out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wheels_cfg     = RST_WHEEL_COUNT;
      offset_cfg     = RST_ANGLE_OFS;
      radius_cfg     = RST_ROBOT_RAD;
      inv_radius_cfg = RST_INV_WHEEL;
      timeout_cfg    = RST_TIMEOUT;
      hold_vx = '0;
      hold_vy = '0;
      hold_wz = '0;
      ref_vx  = '0;
      ref_vy  = '0;
      ref_wz  = '0;
      hold_ok   = 1'b0;
      ref_valid = 1'b0;
      hold_age  = '0;
      expected_speeds.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        write_register(paddr[ADDR_W-1:2], pwdata);
      if (in_valid && !in_stall) apply_request();
      if (out_valid && !out_stall) check_result();
    end
    fail_count <= errors;
    pending    <= expected_speeds.size();
  end

endmodule

[bench/omni_wheel_velocity_mixer_tb.sv]
// Testbench top for the omni-wheel velocity mixer: clock, reset, register writes and
// request/result traffic with random idling. Depends on owvm_pkg, the mixer RTL and
// wheel_speed_checker.
module omni_wheel_velocity_mixer_tb;
  import owvm_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 1000;  // covers a full tick of 8 wheels, with margin
  localparam int LONG_HOLD       = 600;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 35;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_cmd = CMD_VELOCITY;
  logic [VEL_W-1:0]    in_vel_x = '0;
  logic [VEL_W-1:0]    in_vel_y = '0;
  logic [VEL_W-1:0]    in_yaw_rate = '0;
  logic                in_values_ok = 1'b0;
  logic [AGE_W-1:0]    in_arrival_age = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [IDX_OUT_W-1:0] out_wheel_index;
  logic [SPEED_W-1:0]  out_wheel_speed;
  logic                out_last;

  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  int               send_gap_max = 0;
  int               recv_gap_max = 0;
  bit               long_hold_req = 1'b0;
  logic [AGE_W-1:0] timeout_now = RST_TIMEOUT;

  omni_wheel_velocity_mixer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_yaw_rate     (in_yaw_rate),
    .in_values_ok    (in_values_ok),
    .in_arrival_age  (in_arrival_age),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_wheel_index (out_wheel_index),
    .out_wheel_speed (out_wheel_speed),
    .out_last        (out_last)
  );

  wheel_speed_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_yaw_rate     (in_yaw_rate),
    .in_values_ok    (in_values_ok),
    .in_arrival_age  (in_arrival_age),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_wheel_index (out_wheel_index),
    .out_wheel_speed (out_wheel_speed),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] wheels, input logic [DATA_W-1:0] ofs,
                           input logic [DATA_W-1:0] radius, input logic [DATA_W-1:0] inv,
                           input logic [DATA_W-1:0] tmo);
    write_reg(REG_WHEEL_COUNT, wheels);
    write_reg(REG_ANGLE_OFS, ofs);
    write_reg(REG_ROBOT_RAD, radius);
    write_reg(REG_INV_WHEEL, inv);
    write_reg(REG_TIMEOUT, tmo);
    timeout_now = tmo;
  endtask

  task automatic send_request(input logic cmd, input logic [VEL_W-1:0] vx,
                              input logic [VEL_W-1:0] vy, input logic [VEL_W-1:0] wz,
                              input logic ok, input logic [AGE_W-1:0] age);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_vel_x       <= vx;
    in_vel_y       <= vy;
    in_yaw_rate    <= wz;
    in_values_ok   <= ok;
    in_arrival_age <= age;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_command(input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
                              input logic [VEL_W-1:0] wz, input logic ok,
                              input logic [AGE_W-1:0] age);
    send_request(CMD_VELOCITY, vx, vy, wz, ok, age);
  endtask

  // ticks carry junk in the fields they ignore
  task automatic send_tick();
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom(), 1'($urandom()), $urandom());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VEL_W-1:0] random_velocity();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom();
    if (r < 9) return $urandom_range(0, 1 << 19) - (1 << 18);
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // mostly a fresh command followed by a run of ticks; some lone ticks and junk commands
  task automatic random_traffic(input int count);
    int               sent, ticks, age_hi, kind;
    logic [AGE_W-1:0] age;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        if (timeout_now == 0 || timeout_now > 41) age_hi = 40;
        else age_hi = timeout_now - 1;
        age = $urandom_range(0, age_hi);
        send_command(random_velocity(), random_velocity(), random_velocity(), 1'b1, age);
        ticks = $urandom_range(1, 4);
        repeat (ticks) send_tick();
        sent += 1 + ticks;
      end else if (kind == 8) begin
        send_command(random_velocity(), random_velocity(), random_velocity(),
                     1'($urandom()), $urandom());
        sent++;
      end else begin
        send_tick();
        sent++;
      end
    end
  endtask

  initial begin : receiver
    int hold;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = $urandom_range(0, recv_gap_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0] wheels, radius, inv, tmo;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    send_gap_max = 3;
    recv_gap_max = 3;
    send_tick();  // no references yet: nothing comes out
    send_command(32'd65536, '0, '0, 1'b0, '0);
    send_tick();  // held command not usable: still nothing
    send_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '0);
    send_tick();
    send_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'd499);
    send_tick();  // age lands exactly on the timeout: still live
    send_tick();  // one past: brake to zero
    send_command(32'd65536, 32'd65536, 32'd65536, 1'b1, 32'd500);  // stale, dropped
    send_tick();
    send_command(32'd65536, -32'sd32768, 32'sd16384, 1'b1, 32'd10);
    send_tick();
    send_command(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0, '0);
    send_tick();  // unusable command keeps the old references
    drain();

    // timeout disabled: every command held, every tick brakes; age saturates
    send_gap_max = 0;
    recv_gap_max = 0;
    configure(32'd8, 32'd4095, 32'h7FFF_FFFF, '0, '0);
    send_command(random_velocity(), random_velocity(), random_velocity(), 1'b1, '1);
    send_tick();
    send_tick();
    drain();

    // wheel count below range, maximum timeout, age runs into saturation
    send_gap_max = 18;
    recv_gap_max = 18;
    configure('0, 32'd2048, '0, 32'h7FFF_FFFF, '1);
    send_command(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b1, 32'hFFFF_FFFE);
    send_tick();
    send_tick();
    drain();

    // wheel count above range, tiny timeout
    configure(32'd15, 32'd1024, 32'd1, 32'd65536, 32'd3);
    send_command(random_velocity(), random_velocity(), random_velocity(), 1'b1, 32'd2);
    send_tick();
    send_tick();
    send_command(random_velocity(), random_velocity(), random_velocity(), 1'b1, 32'd3);
    send_tick();
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wheels = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 8);
      radius = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                           : $urandom_range(0, 1 << 17);
      inv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                        : $urandom_range(0, 1 << 21);
      case ($urandom_range(0, 4))
        0:       tmo = '0;
        1:       tmo = $urandom_range(1, 30);
        2:       tmo = 32'd500;
        3:       tmo = '1;
        default: tmo = $urandom();
      endcase
      configure(wheels, $urandom_range(0, 4095), radius, inv, tmo);
      case (p)
        0: begin send_gap_max = 18; recv_gap_max = 18; end
        1: begin send_gap_max = 0;  recv_gap_max = 0;  end
        2: begin
          // receiver goes quiet while requests keep coming, so the block backs up
          send_gap_max = 0;
          recv_gap_max = 6;
          long_hold_req = 1'b1;
        end
        3: begin send_gap_max = 18; recv_gap_max = 0;  end
        4: begin send_gap_max = 0;  recv_gap_max = 18; end
        default: begin send_gap_max = 18; recv_gap_max = 18; end
      endcase
      random_traffic(ITEMS_PER_PHASE);
      drain();
    end

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
